[hw/rtl/rht_pkg.sv]
// ----------------------------------------------------------------------------
// rht_pkg
// Shared types, constants and helpers of the remote health tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rht_pkg;

    localparam int REMOTES    = 16;
    localparam int COUNT_BITS = 8;
    localparam int IDX_BITS   = (REMOTES > 1) ? $clog2(REMOTES) : 1;

    localparam int THR_BITS      = 8;
    localparam int CFG_IDX_BITS  = 1;
    localparam int REPORT_BITS   = 8;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_THRESHOLD   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DOWN_THRESHOLD = 1'd1;

    localparam logic [THR_BITS-1:0] UP_THRESHOLD_RESET   = 8'd1;
    localparam logic [THR_BITS-1:0] DOWN_THRESHOLD_RESET = 8'd3;

    // DNS checks
    localparam logic [7:0]  RCODE_MASK     = 8'h0F;
    localparam logic [15:0] DNS_HEADER_MIN = 16'd12;

    localparam logic KIND_RESPONSE = 1'b0;
    localparam logic KIND_TIMEOUT  = 1'b1;

    localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic        kind;
        logic [3:0]  remote;
        logic        payload_ok;
        logic [15:0] dns_length;
        logic [7:0]  dns_flags_low;
        logic [15:0] answer_count;
    } probe_t;

    typedef struct packed {
        logic [3:0]             remote_id;
        logic                   probe_ok;
        logic                   remote_up;
        logic                   went_up;
        logic                   went_down;
        logic [REPORT_BITS-1:0] success_run;
        logic [REPORT_BITS-1:0] failure_run;
    } status_t;

    // one word of the per-remote state table
    typedef struct packed {
        logic                  up;
        logic [COUNT_BITS-1:0] fail_run;
        logic [COUNT_BITS-1:0] succ_run;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{up: 1'b1, fail_run: '0, succ_run: '0};

    // decoded probe held while the table read is in flight
    typedef struct packed {
        logic [3:0] remote;
        logic       ok;
        logic       in_range;
    } probe_ctx_t;

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_TOP) ? COUNT_TOP : v + 1'b1;
    endfunction

    function automatic logic [REPORT_BITS-1:0] report_run(input logic [COUNT_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'd255) ? {REPORT_BITS{1'b1}} : w[REPORT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rht_state_ram.sv]
// ----------------------------------------------------------------------------
// rht_state_ram
// Per-remote state table: one write port, one registered read port.
// Entries not yet written read as the reset state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rht_state_ram (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         rd_en,
    input  wire logic [rht_pkg::IDX_BITS-1:0] rd_addr,
    output rht_pkg::entry_t                   rd_data,
    input  wire logic                         wr_en,
    input  wire logic [rht_pkg::IDX_BITS-1:0] wr_addr,
    input  wire rht_pkg::entry_t              wr_data
);

    rht_pkg::entry_t                ram_reg [rht_pkg::REMOTES];
    logic [rht_pkg::REMOTES-1:0]    vld_reg;
    rht_pkg::entry_t                rd_word_reg;
    logic                           rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= ram_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_word_reg : rht_pkg::ENTRY_RESET;

endmodule

`default_nettype wire

[hw/rtl/rht_update.sv]
// ----------------------------------------------------------------------------
// rht_update
// Read-modify step: run counters, up/down decision and the status word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rht_update (
    input  wire rht_pkg::probe_ctx_t           ctx,
    input  wire rht_pkg::entry_t               cur,
    input  wire logic [rht_pkg::THR_BITS-1:0]  up_limit,
    input  wire logic [rht_pkg::THR_BITS-1:0]  down_limit,
    output rht_pkg::entry_t                    nxt,
    output rht_pkg::status_t                   result
);

    logic went_up;
    logic went_down;

    always_comb
    begin
        nxt       = cur;
        went_up   = 1'b0;
        went_down = 1'b0;
        if (ctx.ok)
        begin
            nxt.fail_run = '0;
            nxt.succ_run = rht_pkg::bump(cur.succ_run);
            if (!cur.up && (32'(nxt.succ_run) >= 32'(up_limit)))
            begin
                nxt.up  = 1'b1;
                went_up = 1'b1;
            end
        end
        else
        begin
            nxt.succ_run = '0;
            nxt.fail_run = rht_pkg::bump(cur.fail_run);
            if (cur.up && (32'(nxt.fail_run) >= 32'(down_limit)))
            begin
                nxt.up    = 1'b0;
                went_down = 1'b1;
            end
        end

        result.remote_id = ctx.remote;
        result.probe_ok  = ctx.ok;
        if (ctx.in_range)
        begin
            result.remote_up   = nxt.up;
            result.went_up     = went_up;
            result.went_down   = went_down;
            result.success_run = rht_pkg::report_run(nxt.succ_run);
            result.failure_run = rht_pkg::report_run(nxt.fail_run);
        end
        else
        begin
            result.remote_up   = 1'b0;
            result.went_up     = 1'b0;
            result.went_down   = 1'b0;
            result.success_run = '0;
            result.failure_run = '0;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/remote_health_tracker_core.sv]
// ----------------------------------------------------------------------------
// remote_health_tracker_core
// Tracks success/failure runs and the up flag of each remote from probe
// outcomes; one status transfer per probe transfer.
// ----------------------------------------------------------------------------
//  channel | ports                              | role
//  probe   | probe_valid, probe_stall, probe    | probe outcome in
//  status  | status_valid, status_stall, status | per-probe status out
//  config  | cfg_we, cfg_index, cfg_data        | threshold writes
//
//  Per probe: table read on the transfer edge, update and write-back when
//  the status register can take the result. A new probe waits until then.
//  probe_stall is high while a probe waits on its table read or on a full,
//  stalled status register; one status may wait while the next probe reads.
//  Reset clears table valid bits at once; no clearing pass, entries read
//  as counters zero and remote up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module remote_health_tracker_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             probe_valid,
    output logic                                  probe_stall,
    input  wire rht_pkg::probe_t                  probe,
    output logic                                  status_valid,
    input  wire logic                             status_stall,
    output rht_pkg::status_t                      status,
    input  wire logic                             cfg_we,
    input  wire logic [rht_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [rht_pkg::THR_BITS-1:0]     cfg_data
);

    logic [rht_pkg::THR_BITS-1:0] up_thr_reg;
    logic [rht_pkg::THR_BITS-1:0] down_thr_reg;

    logic                 p1_valid_reg;
    logic                 p1_valid_next;
    rht_pkg::probe_ctx_t  p1_ctx_reg;
    rht_pkg::probe_ctx_t  p1_ctx_next;

    logic                 status_valid_reg;
    logic                 status_valid_next;
    rht_pkg::status_t     status_reg;

    logic                 accept;
    logic                 p1_done;
    rht_pkg::entry_t      cur_entry;
    rht_pkg::entry_t      nxt_entry;
    rht_pkg::status_t     result;

    assign probe_stall = p1_valid_reg;
    assign accept      = probe_valid && !probe_stall;
    assign p1_done     = p1_valid_reg && (!status_valid_reg || !status_stall);

    // decode the probe at the transfer
    always_comb
    begin
        p1_ctx_next.remote   = probe.remote;
        p1_ctx_next.in_range = (32'(probe.remote) < rht_pkg::REMOTES);
        p1_ctx_next.ok       = (probe.kind == rht_pkg::KIND_RESPONSE)
                               && probe.payload_ok
                               && (probe.dns_length >= rht_pkg::DNS_HEADER_MIN)
                               && ((probe.dns_flags_low & rht_pkg::RCODE_MASK) == 8'h00)
                               && (probe.answer_count != 16'd0);
    end

    always_comb
    begin
        p1_valid_next = p1_valid_reg;
        if (accept)
        begin
            p1_valid_next = 1'b1;
        end
        else if (p1_done)
        begin
            p1_valid_next = 1'b0;
        end

        status_valid_next = status_valid_reg;
        if (p1_done)
        begin
            status_valid_next = 1'b1;
        end
        else if (!status_stall)
        begin
            status_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_thr_reg       <= rht_pkg::UP_THRESHOLD_RESET;
            down_thr_reg     <= rht_pkg::DOWN_THRESHOLD_RESET;
            p1_valid_reg     <= 1'b0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rht_pkg::REG_UP_THRESHOLD:   up_thr_reg   <= cfg_data;
                    rht_pkg::REG_DOWN_THRESHOLD: down_thr_reg <= cfg_data;
                    default: ;
                endcase
            end
            p1_valid_reg     <= p1_valid_next;
            status_valid_reg <= status_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_ctx_reg <= p1_ctx_next;
        end
        if (p1_done)
        begin
            status_reg <= result;
        end
    end

    rht_state_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rht_pkg::IDX_BITS'(probe.remote)),
        .rd_data (cur_entry),
        .wr_en   (p1_done && p1_ctx_reg.in_range),
        .wr_addr (rht_pkg::IDX_BITS'(p1_ctx_reg.remote)),
        .wr_data (nxt_entry)
    );

    rht_update u_update (
        .ctx        (p1_ctx_reg),
        .cur        (cur_entry),
        .up_limit   (up_thr_reg),
        .down_limit (down_thr_reg),
        .nxt        (nxt_entry),
        .result     (result)
    );

    assign status_valid = status_valid_reg;
    assign status       = status_reg;

`ifndef SYNTH
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (probe_valid && !probe_stall) |=> p1_valid_reg)
        else $error("accepted probe not held for update");

    a_single_edge: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid |-> !(status.went_up && status.went_down))
        else $error("went_up and went_down together");

    a_up_on_success: assert property (@(posedge clk) disable iff (!rst_n)
        (status_valid && status.went_up) |-> (status.remote_up && status.probe_ok))
        else $error("went_up without success or up flag");

    a_one_run: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid |-> (status.success_run == 8'd0 || status.failure_run == 8'd0))
        else $error("success and failure runs both nonzero");
`endif

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives probe outcomes into remote_health_tracker_core under random idling
// and back-pressure, predicts each status from its own per-remote run
// counters and up flags, and compares every status transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int HOLD_OFF_CYCLES = 64;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic probe_valid = 1'b0;
    logic probe_stall;
    rht_pkg::probe_t probe = '0;
    logic status_valid;
    logic status_stall = 1'b0;
    rht_pkg::status_t status;
    logic cfg_we = 1'b0;
    logic [rht_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [rht_pkg::THR_BITS-1:0] cfg_data = '0;

    // probes waiting to be driven, statuses predicted but not yet seen
    rht_pkg::probe_t probe_backlog[$];
    rht_pkg::status_t status_pending[$];

    // predicted table and thresholds
    logic [rht_pkg::COUNT_BITS-1:0] succ_runs[rht_pkg::REMOTES];
    logic [rht_pkg::COUNT_BITS-1:0] fail_runs[rht_pkg::REMOTES];
    logic up_now[rht_pkg::REMOTES];
    logic [rht_pkg::THR_BITS-1:0] up_need = rht_pkg::UP_THRESHOLD_RESET;
    logic [rht_pkg::THR_BITS-1:0] down_need = rht_pkg::DOWN_THRESHOLD_RESET;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int probes_taken = 0;
    int mismatches = 0;
    int hold_off_req = 0;
    int hold_off_done = 0;
    int hold_off_left = 0;
    int quiet_cycles = 0;

    remote_health_tracker_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .probe_valid  (probe_valid),
        .probe_stall  (probe_stall),
        .probe        (probe),
        .status_valid (status_valid),
        .status_stall (status_stall),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < rht_pkg::REMOTES; i++)
        begin
            succ_runs[i] = '0;
            fail_runs[i] = '0;
            up_now[i] = 1'b1;
        end
    end

    // Applies one probe to the predicted table and returns the status it yields.
    function automatic rht_pkg::status_t next_status(input rht_pkg::probe_t p);
        rht_pkg::status_t s;
        logic good;
        logic [3:0] r;
        good = (p.kind == rht_pkg::KIND_RESPONSE) && p.payload_ok
            && (p.dns_length >= rht_pkg::DNS_HEADER_MIN)
            && ((p.dns_flags_low & rht_pkg::RCODE_MASK) == 8'h00)
            && (p.answer_count != 16'd0);
        r = p.remote;
        s = '0;
        s.remote_id = r;
        s.probe_ok = good;
        if (good)
        begin
            fail_runs[r] = '0;
            if (succ_runs[r] != {rht_pkg::COUNT_BITS{1'b1}})
                succ_runs[r] = succ_runs[r] + 1'b1;
            if (!up_now[r] && succ_runs[r] >= up_need)
            begin
                up_now[r] = 1'b1;
                s.went_up = 1'b1;
            end
        end
        else
        begin
            succ_runs[r] = '0;
            if (fail_runs[r] != {rht_pkg::COUNT_BITS{1'b1}})
                fail_runs[r] = fail_runs[r] + 1'b1;
            if (up_now[r] && fail_runs[r] >= down_need)
            begin
                up_now[r] = 1'b0;
                s.went_down = 1'b1;
            end
        end
        s.remote_up = up_now[r];
        s.success_run = succ_runs[r];
        s.failure_run = fail_runs[r];
        return s;
    endfunction

    function automatic rht_pkg::probe_t make_probe(input logic kind, input logic [3:0] remote,
                                                   input logic payload_ok,
                                                   input logic [15:0] len,
                                                   input logic [7:0] flags,
                                                   input logic [15:0] answers);
        rht_pkg::probe_t p;
        p.kind = kind;
        p.remote = remote;
        p.payload_ok = payload_ok;
        p.dns_length = len;
        p.dns_flags_low = flags;
        p.answer_count = answers;
        return p;
    endfunction

    function automatic rht_pkg::probe_t random_probe();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(rht_pkg::probe_t)-1:0];
    endfunction

    function automatic rht_pkg::probe_t good_probe(input logic [3:0] remote);
        logic [15:0] len;
        logic [15:0] answers;
        case ($urandom_range(2))
            0: len = rht_pkg::DNS_HEADER_MIN;
            1: len = 16'hFFFF;
            default: len = 16'($urandom_range(12, 65535));
        endcase
        case ($urandom_range(2))
            0: answers = 16'd1;
            1: answers = 16'hFFFF;
            default: answers = 16'($urandom_range(1, 65535));
        endcase
        // RCODE clear, upper nibble free
        return make_probe(rht_pkg::KIND_RESPONSE, remote, 1'b1, len,
                          {4'($urandom_range(15)), 4'h0}, answers);
    endfunction

    // One forced reason for failure per probe, every other field random.
    function automatic rht_pkg::probe_t bad_probe(input logic [3:0] remote);
        rht_pkg::probe_t p;
        p = random_probe();
        p.remote = remote;
        case ($urandom_range(4))
            0: p.kind = rht_pkg::KIND_TIMEOUT;
            1: p.payload_ok = 1'b0;
            2: p.dns_length = 16'($urandom_range(11));
            3: p.dns_flags_low[3:0] = 4'($urandom_range(1, 15));
            default: p.answer_count = 16'd0;
        endcase
        return p;
    endfunction

    // A run of same-outcome probes on one remote, mixed with noise and the odd
    // flipped outcome; with keep_clean, no flips and the noise avoids that remote.
    task automatic queue_run(input logic [3:0] remote, input logic succeed, input int len,
                             input int density, input logic keep_clean);
        rht_pkg::probe_t p;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < density)
            begin
                if ((succeed ^ ($urandom_range(99) < 5 && !keep_clean)) == 1'b1)
                    p = good_probe(remote);
                else
                    p = bad_probe(remote);
            end
            else
            begin
                p = random_probe();
                if (keep_clean)
                    p.remote = remote ^ 4'($urandom_range(1, 15));
            end
            probe_backlog.push_back(p);
        end
    endtask

    task automatic write_threshold(input logic [rht_pkg::CFG_IDX_BITS-1:0] idx,
                                   input logic [rht_pkg::THR_BITS-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == rht_pkg::REG_UP_THRESHOLD)
            up_need = value;
        else
            down_need = value;
    endtask

    // Everything sent and answered, then a settling wait for the write-back.
    task automatic wait_idle();
        while (probe_backlog.size() != 0 || probe_valid || status_pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // saturate: 0 none, 1 success run to the top, 2 failure run to the top
    task automatic random_phase(input int tx_pct, input int rx_pct,
                                input logic [rht_pkg::THR_BITS-1:0] up_val,
                                input logic [rht_pkg::THR_BITS-1:0] down_val,
                                input int saturate, input int target);
        logic [3:0] r;
        int queued;
        write_threshold(rht_pkg::REG_UP_THRESHOLD, up_val);
        write_threshold(rht_pkg::REG_DOWN_THRESHOLD, down_val);
        @(negedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        queued = 0;
        if (saturate != 0)
        begin
            r = 4'($urandom_range(15));
            // set the up flag opposite to the transition the long run drives
            if (saturate == 1)
                probe_backlog.push_back(bad_probe(r));
            else
                probe_backlog.push_back(good_probe(r));
            queue_run(r, saturate == 1, 280, 95, 1'b1);
            queued = 290;
        end
        while (queued < target)
        begin
            queued += 6;
            queue_run(4'($urandom_range(15)), 1'($urandom_range(1)),
                      $urandom_range(1, 10), 75, 1'b0);
        end
    endtask

    initial
    begin
        int start;
        tx_idle_pct = 19;
        rx_idle_pct = 77;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: thresholds at reset (up 1, down 3)
        probe_backlog.push_back(make_probe(rht_pkg::KIND_RESPONSE, 4'd0, 1'b1, 16'd12,
                                           8'hF0, 16'd1));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_TIMEOUT, 4'd0, 1'b1, 16'd100,
                                           8'h00, 16'd5));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_RESPONSE, 4'd0, 1'b0, 16'd100,
                                           8'h00, 16'd5));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_RESPONSE, 4'd0, 1'b1, 16'd11,
                                           8'h00, 16'd5));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_RESPONSE, 4'd0, 1'b1, 16'd100,
                                           8'h01, 16'd5));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_RESPONSE, 4'd0, 1'b1, 16'd100,
                                           8'h00, 16'd0));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_RESPONSE, 4'd0, 1'b1, 16'd100,
                                           8'hFF, 16'd5));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_RESPONSE, 4'd0, 1'b1, 16'hFFFF,
                                           8'h00, 16'hFFFF));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_TIMEOUT, 4'd15, 1'b1, 16'hFFFF,
                                           8'hFF, 16'hFFFF));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_RESPONSE, 4'd15, 1'b1, 16'hFFFF,
                                           8'hF0, 16'hFFFF));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_RESPONSE, 4'd15, 1'b0, 16'd0,
                                           8'h00, 16'd0));
        // back to back on one remote: down after three, then straight back up
        repeat (3) probe_backlog.push_back(make_probe(rht_pkg::KIND_TIMEOUT, 4'd7, 1'b0,
                                                      16'd0, 8'h00, 16'd0));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_RESPONSE, 4'd7, 1'b1, 16'd40,
                                           8'h80, 16'd2));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_TIMEOUT, 4'd7, 1'b0, 16'd0,
                                           8'h00, 16'd0));
        probe_backlog.push_back(make_probe(rht_pkg::KIND_RESPONSE, 4'd8, 1'b1, 16'd40,
                                           8'h00, 16'd2));
        wait_idle();

        random_phase(19, 77, 8'd255, 8'd1, 1, 380);
        wait_idle();
        random_phase(77, 19, 8'd1, 8'd255, 2, 380);
        wait_idle();

        random_phase(0, 0, rht_pkg::THR_BITS'($urandom_range(1, 6)),
                     rht_pkg::THR_BITS'($urandom_range(1, 6)), 0, 340);
        start = probes_taken;
        while (probes_taken < start + 100)
            @(negedge clk);
        hold_off_req++;
        wait_idle();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // probe driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (probe_valid && !probe_stall)
            begin
                status_pending.push_back(next_status(probe));
                probes_taken++;
            end
            if (!probe_valid || !probe_stall)
            begin
                if (probe_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    probe <= probe_backlog.pop_front();
                    probe_valid <= 1'b1;
                end
                else
                begin
                    probe_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // status monitor and receiver stall
    always @(posedge clk)
    begin
        rht_pkg::status_t want;
        if (rst_n)
        begin
            if (status_valid && !status_stall)
            begin
                if (status_pending.size() == 0)
                begin
                    $error("status transfer with no probe outstanding");
                    mismatches++;
                end
                else
                begin
                    want = status_pending.pop_front();
                    check_field("remote_id", 16'(want.remote_id), 16'(status.remote_id));
                    check_field("probe_ok", 16'(want.probe_ok), 16'(status.probe_ok));
                    check_field("remote_up", 16'(want.remote_up), 16'(status.remote_up));
                    check_field("went_up", 16'(want.went_up), 16'(status.went_up));
                    check_field("went_down", 16'(want.went_down), 16'(status.went_down));
                    check_field("success_run", 16'(want.success_run),
                                16'(status.success_run));
                    check_field("failure_run", 16'(want.failure_run),
                                16'(status.failure_run));
                end
            end
            if (hold_off_req != hold_off_done)
            begin
                hold_off_done = hold_off_req;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                status_stall <= 1'b1;
            end
            else
            begin
                status_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (probe_valid && !probe_stall) || (status_valid && !status_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
